[rtl/rv64i_pkg.sv]
package rv64i_pkg;

	localparam int unsigned NumRegs = 32;
	localparam int unsigned RegIdxW = $clog2(NumRegs);

	localparam logic [6:0] OpcOpImm   = 7'b0010011;
	localparam logic [6:0] OpcOpImm32 = 7'b0011011;
	localparam logic [6:0] OpcOp      = 7'b0110011;
	localparam logic [6:0] OpcLui     = 7'b0110111;
	localparam logic [6:0] OpcAuipc   = 7'b0010111;
	localparam logic [6:0] OpcBranch  = 7'b1100011;
	localparam logic [6:0] OpcLoad    = 7'b0000011;
	localparam logic [6:0] OpcStore   = 7'b0100011;
	localparam logic [6:0] OpcJal     = 7'b1101111;
	localparam logic [6:0] OpcJalr    = 7'b1100111;
	localparam logic [6:0] OpcSystem  = 7'b1110011;
	localparam logic [6:0] OpcMiscMem = 7'b0001111;
	localparam logic [5:0] ShamtMask  = 6'b111111;

	typedef enum logic [1:0] {
		REQ_INSN    = 2'd0,
		REQ_LDATA   = 2'd1,
		REQ_CONTROL = 2'd2,
		REQ_BAD     = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_ILLEGAL = 3'd1,
		ST_HALT    = 3'd2,
		ST_BADCTL  = 3'd3,
		ST_SEQ     = 3'd4,
		ST_ASLEEP  = 3'd5
	} status_t;

	typedef struct packed {
		logic        we;
		logic [4:0]  rd;
		logic [63:0] wdata;
	} wb_t;

	typedef struct packed {
		logic [63:0] next_pc;
		logic        mem_valid;
		logic        mem_write;
		logic [63:0] mem_addr;
		logic [1:0]  mem_size_log2;
		logic [63:0] mem_wdata;
		status_t     status;
		logic        sleeping;
	} result_t;

endpackage

[rtl/rv64i_regfile.sv]
module rv64i_regfile (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rd_en,
	input  logic [4:0]  rs1,
	input  logic [4:0]  rs2,
	input  rv64i_pkg::wb_t wb,
	output logic [63:0] rdata1,
	output logic [63:0] rdata2
);
	import rv64i_pkg::*;

	logic [63:0]        mem [NumRegs];
	logic [NumRegs-1:0] vld_q;
	logic [63:0]        raw1_s1, raw2_s1;
	logic               ok1_s1, ok2_s1;
	logic [RegIdxW-1:0] a1, a2, aw;

	assign a1 = rs1[RegIdxW-1:0];
	assign a2 = rs2[RegIdxW-1:0];
	assign aw = wb.rd[RegIdxW-1:0];

	always_ff @(posedge clk) begin
		if (wb.we) begin
			mem[aw] <= wb.wdata;
		end
		if (rd_en) begin
			raw1_s1 <= mem[a1];
			raw2_s1 <= mem[a2];
		end
	end

	// valid bits give reset-to-zero without a clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			ok1_s1 <= 1'b0;
			ok2_s1 <= 1'b0;
		end else begin
			if (wb.we) begin
				vld_q[aw] <= 1'b1;
			end
			if (rd_en) begin
				ok1_s1 <= (rs1 != 5'd0) && (32'(rs1) < NumRegs) && vld_q[a1];
				ok2_s1 <= (rs2 != 5'd0) && (32'(rs2) < NumRegs) && vld_q[a2];
			end
		end
	end

	assign rdata1 = ok1_s1 ? raw1_s1 : 64'd0;
	assign rdata2 = ok2_s1 ? raw2_s1 : 64'd0;

endmodule

[rtl/rv64i_integer_core_step.sv]
// channel | direction | handshake     | payload
// in      | input     | in_valid/in_stall | req_type, insn_word, load_data, control_value
// out     | output    | out_valid/out_stall | next_pc .. sleeping
// cfg     | input     | cfg_we        | cfg_wdata (start_address)
// one item per cycle unless in_stall; a result passes the stage 1 and output registers
// stage 1 reads the register memory, stage 2 executes and writes back
// a write back in stage 2 is forwarded to a same-register read in stage 1
// reset clears the register valid bits, pc to zero and all flags
// out_stall holds the output register; input stalls only when it is full
module rv64i_integer_core_step (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [31:0] insn_word,
	input  logic [63:0] load_data,
	input  logic [63:0] control_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] next_pc,
	output logic        mem_valid,
	output logic        mem_write,
	output logic [63:0] mem_addr,
	output logic [1:0]  mem_size_log2,
	output logic [63:0] mem_wdata,
	output logic [2:0]  status,
	output logic        sleeping,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata
);
	import rv64i_pkg::*;

	logic        v_s1;
	logic [1:0]  type_s1;
	logic [31:0] w_s1;
	logic [63:0] ld_s1, ctl_s1;
	logic [63:0] pc_q, start_q;
	logic        lp_q, lu_q, asleep_q;
	logic [4:0]  ldst_q;
	logic [1:0]  lsz_q;
	logic        ov_q;
	result_t     res_q, res;
	wb_t         wb;
	logic [63:0] ra, rb, a, b;
	logic        adv, acc;
	logic [4:0]  rs1_s1, rs2_s1;
	logic        fwd1, fwd2;
	logic [63:0] fw_d_q;
	logic        fw_v1_q, fw_v2_q;

	// pipeline moves when the output register is free or being taken
	assign adv      = !ov_q || !out_stall;
	assign in_stall = !adv;
	assign acc      = in_valid && adv;

	assign fwd1 = wb.we && (wb.rd == insn_word[19:15]);
	assign fwd2 = wb.we && (wb.rd == insn_word[24:20]);

	rv64i_regfile u_rf (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (acc),
		.rs1    (insn_word[19:15]),
		.rs2    (insn_word[24:20]),
		.wb     (wb),
		.rdata1 (ra),
		.rdata2 (rb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			fw_v1_q <= 1'b0;
			fw_v2_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= in_valid;
			fw_v1_q <= in_valid && fwd1;
			fw_v2_q <= in_valid && fwd2;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			type_s1 <= req_type;
			w_s1    <= insn_word;
			ld_s1   <= load_data;
			ctl_s1  <= control_value;
			fw_d_q  <= wb.wdata;
		end
	end

	assign rs1_s1 = w_s1[19:15];
	assign rs2_s1 = w_s1[24:20];
	assign a = fw_v1_q ? fw_d_q : ra;
	assign b = fw_v2_q ? fw_d_q : rb;

	logic        go;
	assign go = v_s1 && adv;

	// execute
	logic [6:0]  op, f7;
	logic [2:0]  f3;
	logic [4:0]  rd;
	logic [5:0]  hi6, sh6, s;
	logic [63:0] imm_i, imm_s, imm_u, off_j, off_b, sum_i, rv, nxt, a32, w32;
	logic        ill, halt, wr, ldgo, tk;
	logic [63:0] pc4;
	logic [7:0]  bits;

	always_comb begin
		op    = w_s1[6:0];
		rd    = w_s1[11:7];
		f3    = w_s1[14:12];
		f7    = w_s1[31:25];
		hi6   = w_s1[31:26];
		sh6   = w_s1[25:20];
		s     = b[5:0] & ShamtMask;
		imm_i = {{52{w_s1[31]}}, w_s1[31:20]};
		imm_s = {{52{w_s1[31]}}, w_s1[31:25], w_s1[11:7]};
		imm_u = {{32{w_s1[31]}}, w_s1[31:12], 12'd0};
		off_j = {{43{w_s1[31]}}, w_s1[31], w_s1[19:12], w_s1[20], w_s1[30:21], 1'b0};
		off_b = {{51{w_s1[31]}}, w_s1[31], w_s1[7], w_s1[30:25], w_s1[11:8], 1'b0};
		sum_i = a + imm_i;
		pc4   = pc_q + 64'd4;
		nxt   = pc4;
		rv    = '0;
		ill   = 1'b0;
		halt  = 1'b0;
		wr    = 1'b1;
		ldgo  = 1'b0;
		tk    = 1'b0;
		a32   = '0;
		w32   = '0;
		res   = '0;
		unique case (op)
			OpcOpImm: begin
				unique case (f3)
					3'd0: rv = sum_i;
					3'd2: rv = {63'd0, $signed(a) < $signed(imm_i)};
					3'd3: rv = {63'd0, a < imm_i};
					3'd4: rv = a ^ imm_i;
					3'd6: rv = a | imm_i;
					3'd7: rv = a & imm_i;
					3'd1: begin
						ill = hi6 != 6'd0;
						rv  = a << sh6;
					end
					default: begin
						if (hi6 == 6'd0) rv = a >> sh6;
						else if (hi6 == 6'h10) rv = 64'($signed(a) >>> sh6);
						else ill = 1'b1;
					end
				endcase
			end
			OpcOpImm32: begin
				a32 = {{32{a[31]}}, a[31:0]};
				if (f3 == 3'd0) w32 = sum_i;
				else if (f3 == 3'd1 && f7 == 7'd0) w32 = a << sh6[4:0];
				else if (f3 == 3'd5 && f7 == 7'd0) w32 = {32'd0, a[31:0]} >> sh6[4:0];
				else if (f3 == 3'd5 && f7 == 7'h20) w32 = 64'($signed(a32) >>> sh6[4:0]);
				else ill = 1'b1;
				rv = {{32{w32[31]}}, w32[31:0]};
			end
			OpcOp: begin
				ill = f7 != 7'd0 && !(f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5));
				unique case (f3)
					3'd0: rv = (f7 != 7'd0) ? a - b : a + b;
					3'd1: rv = a << s;
					3'd2: rv = {63'd0, $signed(a) < $signed(b)};
					3'd3: rv = {63'd0, a < b};
					3'd4: rv = a ^ b;
					3'd5: rv = (f7 != 7'd0) ? 64'($signed(a) >>> s) : a >> s;
					3'd6: rv = a | b;
					default: rv = a & b;
				endcase
			end
			OpcLui:   rv = imm_u;
			OpcAuipc: rv = pc_q + imm_u;
			OpcJal: begin
				rv  = pc4;
				nxt = pc_q + off_j;
			end
			OpcJalr: begin
				ill = f3 != 3'd0;
				rv  = pc4;
				nxt = {sum_i[63:1], 1'b0};
			end
			OpcBranch: begin
				wr = 1'b0;
				unique case (f3)
					3'd0: tk = a == b;
					3'd1: tk = a != b;
					3'd4: tk = $signed(a) < $signed(b);
					3'd5: tk = !($signed(a) < $signed(b));
					3'd6: tk = a < b;
					3'd7: tk = a >= b;
					default: ill = 1'b1;
				endcase
				if (tk) nxt = pc_q + off_b;
			end
			OpcLoad: begin
				wr  = 1'b0;
				ill = f3 == 3'd7;
				ldgo = 1'b1;
				res.mem_valid     = 1'b1;
				res.mem_addr      = sum_i;
				res.mem_size_log2 = f3[1:0];
			end
			OpcStore: begin
				wr  = 1'b0;
				ill = f3[2];
				res.mem_valid     = 1'b1;
				res.mem_write     = 1'b1;
				res.mem_addr      = a + imm_s;
				res.mem_size_log2 = f3[1:0];
				res.mem_wdata     = b;
			end
			OpcMiscMem: wr = 1'b0;
			OpcSystem:  halt = 1'b1;
			default:    ill = 1'b1;
		endcase
		if (ill || halt) begin
			res.mem_valid     = 1'b0;
			res.mem_write     = 1'b0;
			res.mem_addr      = '0;
			res.mem_size_log2 = '0;
			res.mem_wdata     = '0;
		end
		bits = 8'd8 << lsz_q;
	end

	// state update and write back
	logic [63:0] pc_d, ldv;
	logic        lp_d, as_d;
	status_t     st;
	logic        doexe;

	always_comb begin
		pc_d  = pc_q;
		lp_d  = lp_q;
		as_d  = asleep_q;
		st    = ST_OK;
		doexe = 1'b0;
		wb    = '0;
		ldv   = ld_s1;
		unique case (lsz_q)
			2'd0: ldv = lu_q ? {56'd0, ld_s1[7:0]} : {{56{ld_s1[7]}}, ld_s1[7:0]};
			2'd1: ldv = lu_q ? {48'd0, ld_s1[15:0]} : {{48{ld_s1[15]}}, ld_s1[15:0]};
			2'd2: ldv = lu_q ? {32'd0, ld_s1[31:0]} : {{32{ld_s1[31]}}, ld_s1[31:0]};
			default: ldv = ld_s1;
		endcase
		unique case (req_t'(type_s1))
			REQ_INSN: begin
				if (asleep_q) st = ST_ASLEEP;
				else if (lp_q) st = ST_SEQ;
				else if (ill) st = ST_ILLEGAL;
				else if (halt) st = ST_HALT;
				else begin
					doexe = 1'b1;
					pc_d  = nxt;
					if (ldgo) lp_d = 1'b1;
					wb.we    = wr && rd != 5'd0 && 32'(rd) < NumRegs;
					wb.rd    = rd;
					wb.wdata = rv;
				end
			end
			REQ_LDATA: begin
				if (!lp_q) st = ST_SEQ;
				else begin
					lp_d     = 1'b0;
					wb.we    = ldst_q != 5'd0 && 32'(ldst_q) < NumRegs;
					wb.rd    = ldst_q;
					wb.wdata = ldv;
				end
			end
			REQ_CONTROL: begin
				if (ctl_s1 == 64'd0) as_d = 1'b1;
				else if (ctl_s1 == 64'd1) as_d = 1'b0;
				else st = ST_BADCTL;
			end
			default: st = ST_SEQ;
		endcase
		if (!go) wb.we = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= '0;
			start_q  <= '0;
			lp_q     <= 1'b0;
			lu_q     <= 1'b0;
			ldst_q   <= '0;
			lsz_q    <= '0;
			asleep_q <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				start_q <= cfg_wdata;
				pc_q    <= cfg_wdata;
			end else if (go) begin
				pc_q <= pc_d;
			end
			if (go) begin
				lp_q     <= lp_d;
				asleep_q <= as_d;
				if (doexe && ldgo) begin
					ldst_q <= rd;
					lsz_q  <= f3[1:0];
					lu_q   <= f3[2];
				end
			end
			if (adv) ov_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res_q          <= res;
			res_q.next_pc  <= pc_d;
			res_q.status   <= st;
			res_q.sleeping <= as_d;
			if (!doexe) begin
				res_q.mem_valid     <= 1'b0;
				res_q.mem_write     <= 1'b0;
				res_q.mem_addr      <= '0;
				res_q.mem_size_log2 <= '0;
				res_q.mem_wdata     <= '0;
			end
		end
	end

	assign out_valid     = ov_q;
	assign next_pc       = res_q.next_pc;
	assign mem_valid     = res_q.mem_valid;
	assign mem_write     = res_q.mem_write;
	assign mem_addr      = res_q.mem_addr;
	assign mem_size_log2 = res_q.mem_size_log2;
	assign mem_wdata     = res_q.mem_wdata;
	assign status        = res_q.status;
	assign sleeping      = res_q.sleeping;

	logic unused;
	assign unused = ^{start_q, bits, rs1_s1, rs2_s1};

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(next_pc))
		else $error("result changed under stall");
	a_no_wb_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> !wb.we)
		else $error("write back without item");
	a_insn_pending: assert property (@(posedge clk) disable iff (!arst_n)
		go && lp_q && type_s1 == REQ_INSN |-> !wb.we)
		else $error("execute with load pending");

endmodule

[verif/rv64i_integer_core_step_checker.sv]
module rv64i_integer_core_step_checker
	import rv64i_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [31:0] insn_word,
	input  logic [63:0] load_data,
	input  logic [63:0] control_value,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [63:0] next_pc,
	input  logic        mem_valid,
	input  logic        mem_write,
	input  logic [63:0] mem_addr,
	input  logic [1:0]  mem_size_log2,
	input  logic [63:0] mem_wdata,
	input  logic [2:0]  status,
	input  logic        sleeping,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata,
	output int          fail_count,
	output int          pending_results
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [63:0] regs [32];
	logic [63:0] pc;
	logic        ld_busy;
	logic [4:0]  ld_rd;
	logic [1:0]  ld_size;
	logic        ld_uns;
	logic        dozing;
	result_t     expected_q [$];

	function automatic logic [63:0] rd_reg(logic [4:0] i);
		if (i == 0 || i >= NumRegs)
			return 64'd0;
		return regs[i];
	endfunction

	function automatic void wr_reg(logic [4:0] i, logic [63:0] v);
		if (i != 0 && i < NumRegs)
			regs[i] = v;
	endfunction

	function automatic logic [63:0] sx32(logic [63:0] v);
		return {{32{v[31]}}, v[31:0]};
	endfunction

	function automatic status_t run_insn(logic [31:0] w, inout result_t r);
		logic [6:0]  op;
		logic [4:0]  rd, rs1, rs2;
		logic [2:0]  f3;
		logic [6:0]  f7;
		logic [5:0]  hi6, sh6;
		logic [63:0] a, b, immi, nxt, res, off;
		logic        wr, tk;
		op = w[6:0]; rd = w[11:7]; f3 = w[14:12]; rs1 = w[19:15]; rs2 = w[24:20];
		f7 = w[31:25]; hi6 = w[31:26]; sh6 = w[25:20];
		a = rd_reg(rs1); b = rd_reg(rs2);
		immi = {{52{w[31]}}, w[31:20]};
		nxt = pc + 64'd4; res = '0; wr = 1'b1;
		case (op)
			OpcOpImm: begin
				case (f3)
					3'd0: res = a + immi;
					3'd2: res = 64'($signed(a) < $signed(immi));
					3'd3: res = 64'(a < immi);
					3'd4: res = a ^ immi;
					3'd6: res = a | immi;
					3'd7: res = a & immi;
					3'd1: begin
						if (hi6 != 0) return ST_ILLEGAL;
						res = a << sh6;
					end
					default: begin
						if (hi6 == 0) res = a >> sh6;
						else if (hi6 == 6'h10) res = $signed(a) >>> sh6;
						else return ST_ILLEGAL;
					end
				endcase
			end
			OpcOpImm32: begin
				if (f3 == 0) res = sx32(a + immi);
				else if (f3 == 1 && f7 == 0) res = sx32(a << sh6[4:0]);
				else if (f3 == 5 && f7 == 0) res = sx32({32'd0, a[31:0]} >> sh6[4:0]);
				else if (f3 == 5 && f7 == 7'h20) res = $signed(sx32(a)) >>> sh6[4:0];
				else return ST_ILLEGAL;
			end
			OpcOp: begin
				if (f7 != 0 && !(f7 == 7'h20 && (f3 == 0 || f3 == 5)))
					return ST_ILLEGAL;
				case (f3)
					3'd0: res = f7 != 0 ? a - b : a + b;
					3'd1: res = a << b[5:0];
					3'd2: res = 64'($signed(a) < $signed(b));
					3'd3: res = 64'(a < b);
					3'd4: res = a ^ b;
					3'd5: begin
						if (f7 != 0) res = $signed(a) >>> b[5:0];
						else res = a >> b[5:0];
					end
					3'd6: res = a | b;
					default: res = a & b;
				endcase
			end
			OpcLui: res = {{32{w[31]}}, w[31:12], 12'd0};
			OpcAuipc: res = pc + {{32{w[31]}}, w[31:12], 12'd0};
			OpcJal: begin
				off = {{44{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
				res = pc + 64'd4;
				nxt = pc + off;
			end
			OpcJalr: begin
				if (f3 != 0) return ST_ILLEGAL;
				res = pc + 64'd4;
				nxt = (a + immi) & ~64'd1;
			end
			OpcBranch: begin
				off = {{52{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
				case (f3)
					3'd0: tk = a == b;
					3'd1: tk = a != b;
					3'd4: tk = $signed(a) < $signed(b);
					3'd5: tk = $signed(a) >= $signed(b);
					3'd6: tk = a < b;
					3'd7: tk = a >= b;
					default: return ST_ILLEGAL;
				endcase
				if (tk) nxt = pc + off;
				wr = 1'b0;
			end
			OpcLoad: begin
				if (f3 == 7) return ST_ILLEGAL;
				ld_busy = 1'b1; ld_rd = rd; ld_size = f3[1:0]; ld_uns = f3[2];
				r.mem_valid = 1'b1; r.mem_addr = a + immi; r.mem_size_log2 = f3[1:0];
				wr = 1'b0;
			end
			OpcStore: begin
				if (f3 > 3) return ST_ILLEGAL;
				r.mem_valid = 1'b1; r.mem_write = 1'b1;
				r.mem_addr = a + {{52{w[31]}}, f7, rd};
				r.mem_size_log2 = f3[1:0]; r.mem_wdata = b;
				wr = 1'b0;
			end
			OpcMiscMem: wr = 1'b0;
			OpcSystem: return ST_HALT;
			default: return ST_ILLEGAL;
		endcase
		if (wr) wr_reg(rd, res);
		pc = nxt;
		return ST_OK;
	endfunction

	function automatic result_t step_core(req_t kind, logic [31:0] w, logic [63:0] ld,
			logic [63:0] cv);
		result_t     r;
		logic [63:0] v;
		r = '0;
		r.status = ST_OK;
		case (kind)
			REQ_INSN: begin
				if (dozing) r.status = ST_ASLEEP;
				else if (ld_busy) r.status = ST_SEQ;
				else r.status = run_insn(w, r);
			end
			REQ_LDATA: begin
				if (!ld_busy) r.status = ST_SEQ;
				else begin
					case (ld_size)
						2'd0: v = ld_uns ? {56'd0, ld[7:0]} : {{56{ld[7]}}, ld[7:0]};
						2'd1: v = ld_uns ? {48'd0, ld[15:0]} : {{48{ld[15]}}, ld[15:0]};
						2'd2: v = ld_uns ? {32'd0, ld[31:0]} : {{32{ld[31]}}, ld[31:0]};
						default: v = ld;
					endcase
					wr_reg(ld_rd, v);
					ld_busy = 1'b0;
				end
			end
			REQ_CONTROL: begin
				if (cv == 0) dozing = 1'b1;
				else if (cv == 1) dozing = 1'b0;
				else r.status = ST_BADCTL;
			end
			default: r.status = ST_SEQ;
		endcase
		r.next_pc = pc;
		r.sleeping = dozing;
		return r;
	endfunction

	assign pending_results = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			foreach (regs[i]) regs[i] = '0;
			pc = '0;
			ld_busy = 0; ld_rd = 0; ld_size = 0; ld_uns = 0; dozing = 0;
			expected_q.delete();
			fail_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result transfer, next_pc %h", next_pc);
				end else begin
					e = expected_q.pop_front();
					if (e.next_pc !== next_pc || e.mem_valid !== mem_valid
							|| e.mem_write !== mem_write || e.mem_addr !== mem_addr
							|| e.mem_size_log2 !== mem_size_log2
							|| e.mem_wdata !== mem_wdata || e.status !== status
							|| e.sleeping !== sleeping) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: exp pc %h mv %b mw %b ad %h sz %d wd %h st %d sl %b\n          got pc %h mv %b mw %b ad %h sz %d wd %h st %d sl %b",
								e.next_pc, e.mem_valid, e.mem_write, e.mem_addr,
								e.mem_size_log2, e.mem_wdata, e.status, e.sleeping,
								next_pc, mem_valid, mem_write, mem_addr,
								mem_size_log2, mem_wdata, status, sleeping);
					end
				end
			end
			if (cfg_we)
				pc = cfg_wdata;
			if (in_valid && !in_stall)
				expected_q.push_back(step_core(req_t'(req_type), insn_word, load_data,
					control_value));
		end
	end
endmodule

[verif/rv64i_integer_core_step_test.sv]
module rv64i_integer_core_step_test;
	import rv64i_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [1:0]  req_type = REQ_INSN;
	logic [31:0] insn_word = '0;
	logic [63:0] load_data = '0;
	logic [63:0] control_value = '0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [63:0] next_pc;
	logic        mem_valid, mem_write, sleeping;
	logic [63:0] mem_addr, mem_wdata;
	logic [1:0]  mem_size_log2;
	logic [2:0]  status;
	logic        cfg_we = 0;
	logic [63:0] cfg_wdata = '0;
	int          fail_count, pending_results;
	int          idle_cycles = 0;
	bit          hold_long = 0;
	bit          ld_open = 0;

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	rv64i_integer_core_step dut (.*);

	rv64i_integer_core_step_checker checker_i (.*);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 3000) begin
			$display("rv64i_integer_core_step_test NOT OK");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_long) begin
				out_stall <= 1;
				repeat (60) @(posedge clk);
				hold_long = 0;
			end
			n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
			if ($urandom_range(0, 4) == 0) n = 0;
			if (n > 0) begin
				out_stall <= 1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 0;
			@(posedge clk);
		end
	end

	task automatic send(logic [1:0] k, logic [31:0] w, logic [63:0] ld, logic [63:0] cv,
			bit gaps);
		int n;
		n = gaps ? $urandom_range(0, 13) : 0;
		if (gaps && $urandom_range(0, 2) == 0) n = 0;
		if (n > 0) begin
			in_valid <= 0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1;
		req_type <= k; insn_word <= w; load_data <= ld; control_value <= cv;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_start(logic [63:0] v);
		cfg_we <= 1; cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [31:0] ri(logic [6:0] op, logic [2:0] f3, logic [11:0] imm);
		return {imm, 5'($urandom), f3, 5'($urandom), op};
	endfunction

	function automatic logic [31:0] rand_insn();
		logic [31:0] w;
		int sel;
		w = $urandom;
		sel = $urandom_range(0, 15);
		case (sel)
			0: w[6:0] = OpcOpImm;
			1: begin w[6:0] = OpcOpImm32; w[31:26] = $urandom_range(0, 1) ? 6'h10 : 6'h0; end
			2, 3: begin w[6:0] = OpcOp; w[31:25] = $urandom_range(0, 1) ? 7'h20 : 7'h0; end
			4: w[6:0] = OpcLui;
			5: w[6:0] = OpcAuipc;
			6: w[6:0] = OpcJal;
			7: begin w[6:0] = OpcJalr; w[14:12] = 0; end
			8: w[6:0] = OpcBranch;
			9: w[6:0] = OpcLoad;
			10: begin w[6:0] = OpcStore; w[14] = 0; end
			11: w[6:0] = OpcMiscMem;
			12: w[6:0] = OpcSystem;
			13: begin w[6:0] = OpcOpImm; w[14:12] = $urandom_range(0, 1) ? 3'd1 : 3'd5;
				w[31:26] = $urandom_range(0, 1) ? 6'h10 : 6'h0; end
			14: w[6:0] = OpcOp;
			default: ;
		endcase
		return w;
	endfunction

	task automatic random_item(bit gaps);
		logic [31:0] w;
		int p;
		p = $urandom_range(0, 99);
		if (ld_open && p < 70) begin
			send(REQ_LDATA, $urandom, rnd64(), rnd64(), gaps);
			ld_open = 0;
		end else if (p < 85) begin
			w = rand_insn();
			send(REQ_INSN, w, rnd64(), rnd64(), gaps);
		end else if (p < 90) begin
			send(REQ_LDATA, $urandom, rnd64(), rnd64(), gaps);
			ld_open = 0;
		end else if (p < 97) begin
			send(REQ_CONTROL, $urandom, rnd64(),
				$urandom_range(0, 3) == 0 ? rnd64() : 64'($urandom_range(0, 1)), gaps);
		end else begin
			send(REQ_BAD, $urandom, rnd64(), rnd64(), gaps);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		write_start(64'hFFFF_FFFF_FFFF_FFFC);
		// directed: fill registers, extremes and special cases
		send(REQ_INSN, ri(OpcOpImm, 3'd0, 12'h800) | (32'd1 << 7), '0, '0, 1);
		send(REQ_INSN, {20'hFFFFF, 5'd2, OpcLui}, '0, '0, 1);
		send(REQ_INSN, {20'h7FFFF, 5'd3, OpcLui}, '0, '0, 1);
		send(REQ_INSN, {7'h20, 5'd1, 5'd2, 3'd5, 5'd4, OpcOp}, '0, '0, 1);
		send(REQ_INSN, {7'h00, 5'd3, 5'd1, 3'd1, 5'd5, OpcOp}, '0, '0, 1);
		send(REQ_INSN, {7'h20, 5'd31, 5'd1, 3'd5, 5'd6, OpcOpImm32}, '0, '0, 1);
		send(REQ_INSN, {7'h01, 5'd1, 5'd1, 3'd0, 5'd6, OpcOp}, '0, '0, 1);
		send(REQ_INSN, {12'h000, 5'd0, 3'd1, 5'd0, OpcJalr}, '0, '0, 1);
		send(REQ_INSN, {12'h7FF, 5'd1, 3'd0, 5'd7, OpcJalr}, '0, '0, 1);
		send(REQ_INSN, 32'hFFFF_F0EF, '0, '0, 1);
		send(REQ_INSN, {7'h7F, 5'd2, 5'd1, 3'd4, 5'h1F, OpcBranch}, '0, '0, 1);
		send(REQ_INSN, {7'h3F, 5'd3, 5'd1, 3'd3, 5'd9, OpcStore}, '0, '0, 1);
		send(REQ_INSN, {12'hFFF, 5'd1, 3'd6, 5'd8, OpcLoad}, '0, '0, 1);
		send(REQ_INSN, {12'h0, 5'd0, 3'd0, 5'd0, OpcOpImm}, '0, '0, 1);
		send(REQ_LDATA, '0, 64'hFFFF_FFFF_8000_0000, '0, 1);
		send(REQ_LDATA, '0, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1);
		send(REQ_INSN, {12'h0, 5'd8, 3'd7, 5'd9, OpcLoad}, '0, '0, 1);
		send(REQ_INSN, {25'h0, OpcSystem}, '0, '0, 1);
		send(REQ_INSN, {25'h0, OpcMiscMem}, '0, '0, 1);
		send(REQ_CONTROL, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF, 1);
		send(REQ_CONTROL, '0, '0, 64'd0, 1);
		send(REQ_INSN, 32'hFFFF_FFFF, '0, '0, 1);
		send(REQ_CONTROL, '0, '0, 64'd1, 1);
		send(REQ_BAD, '1, '1, '1, 1);
		drain();
		write_start(64'h0);
		for (int i = 0; i < 300; i++) begin
			if (i == 100) hold_long = 1;
			random_item(i > 150 || (i % 40) < 20);
			if ($urandom_range(0, 9) == 0) ld_open = 1;
		end
		drain();
		write_start(rnd64());
		for (int i = 0; i < 250; i++) begin
			random_item(1);
			if ($urandom_range(0, 9) == 0) ld_open = 1;
		end
		drain();
		write_start(64'hFFFF_FFFF_FFFF_FFFF);
		for (int i = 0; i < 250; i++) begin
			random_item(i % 50 > 10);
			if ($urandom_range(0, 9) == 0) ld_open = 1;
		end
		drain();
		if (fail_count == 0)
			$display("rv64i_integer_core_step_test OK");
		else
			$display("rv64i_integer_core_step_test NOT OK");
		$finish;
	end
endmodule
